// ===== design/mqflc_pkg.sv =====
package mqflc_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int CMD_W   = 2;
  localparam int QSEL_W  = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LOST_W  = 32;

  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WORDS   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(WORDS);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

endpackage

// ===== design/multi_queue_fifo_lost_count_core.sv =====
// Bank of NUM_QUEUES circular word FIFOs, each QUEUE_DEPTH words deep, sharing one word
// memory. Every transaction on the input channel is one command (initialise, write or read)
// for the queue that in_queue_index selects, and produces exactly one result transaction
// carrying a status, the word read and the queue's saturating count of dropped writes.
// One command is accepted per cycle unless a stalled output holds the one before it in the
// input register; each command passes an input register and then a result register, where
// its result is presented. The rate is set by the single port pair of the word memory and
// the per-queue pointer registers, each updated once per cycle. No clearing pass is needed
// after reset.
module multi_queue_fifo_lost_count_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mqflc_pkg::CMD_W-1:0]  in_command,
  input  logic [mqflc_pkg::QSEL_W-1:0] in_queue_index,
  input  logic [mqflc_pkg::DATA_W-1:0] in_write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mqflc_pkg::STAT_W-1:0] out_status,
  output logic [mqflc_pkg::DATA_W-1:0] out_read_data,
  output logic [mqflc_pkg::LOST_W-1:0] out_lost_total
);

  localparam int NQ     = mqflc_pkg::NUM_QUEUES;
  localparam int QIDX_W = mqflc_pkg::QIDX_W;
  localparam int PTR_W  = mqflc_pkg::PTR_W;
  localparam int CNT_W  = mqflc_pkg::CNT_W;
  localparam int ADDR_W = mqflc_pkg::ADDR_W;
  localparam int LOST_W = mqflc_pkg::LOST_W;
  localparam int DATA_W = mqflc_pkg::DATA_W;

  // input stage
  logic                         s1_valid_r;
  logic [mqflc_pkg::CMD_W-1:0]  s1_cmd_r;
  logic [mqflc_pkg::QSEL_W-1:0] s1_qsel_r;
  logic [DATA_W-1:0]            s1_data_r;

  // per-queue state
  logic [PTR_W-1:0]  head_r [NQ];
  logic [PTR_W-1:0]  tail_r [NQ];
  logic [CNT_W-1:0]  fill_r [NQ];
  logic [LOST_W-1:0] lost_r [NQ];

  logic [DATA_W-1:0] mem [mqflc_pkg::WORDS];
  logic [DATA_W-1:0] mem_rdata_r;

  // result stage
  logic                       out_valid_r;
  mqflc_pkg::status_t         status_r;
  logic [LOST_W-1:0]          lost_total_r;
  logic                       rd_ok_r;

  logic                       advance;
  logic                       q_ok;
  logic [QIDX_W-1:0]          sel;
  logic [PTR_W-1:0]           head_nxt;
  logic [PTR_W-1:0]           tail_nxt;
  logic [CNT_W-1:0]           fill_nxt;
  logic [LOST_W-1:0]          lost_nxt;
  mqflc_pkg::status_t         status_nxt;
  logic                       wr_en;
  logic                       rd_ok_nxt;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          base_addr;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign q_ok = ({1'b0, s1_qsel_r} < (mqflc_pkg::QSEL_W + 1)'(NQ));
  assign sel  = s1_qsel_r[QIDX_W-1:0];
  assign base_addr = ADDR_W'(sel) * ADDR_W'(mqflc_pkg::QUEUE_DEPTH);
  assign wr_addr   = base_addr + ADDR_W'(tail_r[sel]);
  assign rd_addr   = base_addr + ADDR_W'(head_r[sel]);

  always_comb begin
    head_nxt   = head_r[sel];
    tail_nxt   = tail_r[sel];
    fill_nxt   = fill_r[sel];
    lost_nxt   = lost_r[sel];
    status_nxt = mqflc_pkg::ST_OK;
    wr_en      = 1'b0;
    rd_ok_nxt  = 1'b0;
    if (!q_ok) begin
      status_nxt = mqflc_pkg::ST_BAD_INDEX;
    end else begin
      case (s1_cmd_r)
        mqflc_pkg::CMD_INIT: begin
          head_nxt = '0;
          tail_nxt = '0;
          fill_nxt = '0;
          lost_nxt = '0;
        end
        mqflc_pkg::CMD_WRITE: begin
          if (fill_r[sel] == CNT_W'(mqflc_pkg::QUEUE_DEPTH)) begin
            status_nxt = mqflc_pkg::ST_FULL;
            if (lost_r[sel] != '1) begin
              lost_nxt = lost_r[sel] + LOST_W'(1);
            end
          end else begin
            wr_en    = 1'b1;
            fill_nxt = fill_r[sel] + CNT_W'(1);
            tail_nxt = (tail_r[sel] == PTR_W'(mqflc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : tail_r[sel] + PTR_W'(1);
          end
        end
        mqflc_pkg::CMD_READ: begin
          if (fill_r[sel] == '0) begin
            status_nxt = mqflc_pkg::ST_EMPTY;
          end else begin
            rd_ok_nxt = 1'b1;
            fill_nxt  = fill_r[sel] - CNT_W'(1);
            head_nxt  = (head_r[sel] == PTR_W'(mqflc_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : head_r[sel] + PTR_W'(1);
          end
        end
        default: begin
          // unused code: report the counter, change nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_command;
      s1_qsel_r <= in_queue_index;
      s1_data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
        lost_r[i] <= '0;
      end
    end else if (advance && q_ok) begin
      head_r[sel] <= head_nxt;
      tail_r[sel] <= tail_nxt;
      fill_r[sel] <= fill_nxt;
      lost_r[sel] <= lost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      mem[wr_addr] <= s1_data_r;
    end
    if (advance) begin
      mem_rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      status_r     <= status_nxt;
      lost_total_r <= q_ok ? lost_nxt : '0;
      rd_ok_r      <= rd_ok_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_data  = rd_ok_r ? mem_rdata_r : '0;
  assign out_lost_total = lost_total_r;

  for (genvar g = 0; g < NQ; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[g] <= CNT_W'(mqflc_pkg::QUEUE_DEPTH))
      else $error("queue fill count above depth");
  end

  a_full_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == mqflc_pkg::ST_FULL |-> lost_total_r != '0)
    else $error("dropped write without lost count");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == mqflc_pkg::ST_BAD_INDEX |->
      lost_total_r == '0 && !rd_ok_r)
    else $error("bad index result carries data");

  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rd_ok_r |-> status_r == mqflc_pkg::ST_OK)
    else $error("read data with non-ok status");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_cmd_r) && $stable(s1_qsel_r)
      && $stable(s1_data_r))
    else $error("stalled command changed in input stage");

endmodule
